// ----- design/walsh_spectrum_of_truth_table_unit_defines.svh -----
// Assertion macros for the Walsh spectrum unit.
// Used by the top level only; no other dependencies.
`ifndef WALSH_SPECTRUM_OF_TRUTH_TABLE_UNIT_DEFINES_SVH
`define WALSH_SPECTRUM_OF_TRUTH_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WST_ASSERT_SAME(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WST_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wst_pkg.sv -----
// Shared types and constants for the Walsh spectrum unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package wst_pkg;

    localparam int DEFAULT_MAX_VARS = 6;
    localparam int TT_W             = 64;
    localparam int COEF_W           = 8;
    localparam int IDX_W            = 6;
    localparam int NV_W             = 3;
    localparam int OUT_TDATA_W      = 16;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_W        = APB_ADDR_W - 2;

    localparam logic [NV_W-1:0]      VAR_COUNT_RESET   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_IDX_VAR_COUNT = 1'b0;

    typedef struct packed {
        logic            valid;
        logic [NV_W-1:0] nvars;
    } wst_ctl_t;

endpackage

`default_nettype wire

// ----- design/wst_bfly_stage.sv -----
// One registered butterfly stage of the Walsh-Hadamard transform.
// Depends on wst_pkg for the control struct and coefficient width.
`default_nettype none

module wst_bfly_stage #(
    parameter int LANES = 64,
    parameter int STAGE = 0
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire wst_pkg::wst_ctl_t                      in_ctl,
    input  wire logic [LANES-1:0][wst_pkg::COEF_W-1:0]  in_data,
    output logic                                        in_ready,
    output wst_pkg::wst_ctl_t                           out_ctl,
    output logic [LANES-1:0][wst_pkg::COEF_W-1:0]       out_data,
    input  wire logic                                   out_ready
);
    import wst_pkg::*;

    localparam int DIST = 1 << STAGE;

    logic [LANES-1:0][COEF_W-1:0] bfly;
    logic [LANES-1:0][COEF_W-1:0] data_next;
    logic [LANES-1:0][COEF_W-1:0] data_reg;
    wst_ctl_t                     ctl_reg;
    logic                         apply;

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        if ((j & DIST) == 0)
        begin : g_sum
            assign bfly[j] = in_data[j] + in_data[j + DIST];
        end
        else
        begin : g_diff
            assign bfly[j] = in_data[j - DIST] - in_data[j];
        end
    end

    // The dimension only takes part when the function has that many variables.
    assign apply     = (NV_W'(STAGE) < in_ctl.nvars);
    assign data_next = apply ? bfly : in_data;
    assign in_ready  = !ctl_reg.valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ----- design/wst_emit.sv -----
// Output serialiser: holds one spectrum and sends its coefficients in index order.
// Depends on wst_pkg for the control struct and field widths.
`default_nettype none

module wst_emit #(
    parameter int LANES = 64,
    parameter int CNT_W = 7
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire wst_pkg::wst_ctl_t                           in_ctl,
    input  wire logic [LANES-1:0][wst_pkg::COEF_W-1:0]       in_data,
    output logic                                             in_ready,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // coeff_index [5:0], coefficient [13:6], zero padding [15:14]
    output logic [wst_pkg::OUT_TDATA_W-1:0]                  m_tdata,
    output logic                                             m_tlast
);
    import wst_pkg::*;

    logic [LANES-1:0][COEF_W-1:0] shreg_reg;
    logic [CNT_W-1:0]             pos_reg;
    logic [CNT_W-1:0]             pos_next;
    logic [NV_W-1:0]              nv_reg;
    logic [NV_W-1:0]              nv_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic [CNT_W-1:0]             size;
    logic [CNT_W-1:0]             pos_inc;
    logic                         last;
    logic                         load;
    logic                         advance;

    assign size     = CNT_W'(1) << nv_reg;
    assign pos_inc  = pos_reg + CNT_W'(1);
    assign last     = busy_reg && (pos_inc == size);
    assign advance  = busy_reg && m_tready;
    assign in_ready = !busy_reg || (m_tready && last);
    assign load     = in_ctl.valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        nv_next   = nv_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            nv_next   = in_ctl.nvars;
        end
        else if (advance)
        begin
            if (last)
            begin
                busy_next = 1'b0;
                pos_next  = '0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
            nv_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            nv_reg   <= nv_next;
        end
    end

    // The spectrum shifts down one lane per word, so lane 0 is always the current word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shreg_reg <= in_data;
        end
        else if (advance)
        begin
            shreg_reg <= {COEF_W'(0), shreg_reg[LANES-1:1]};
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {(OUT_TDATA_W - COEF_W - IDX_W)'(0), shreg_reg[0], IDX_W'(pos_reg)};

endmodule

`default_nettype wire

// ----- design/walsh_spectrum_of_truth_table_unit.sv -----
// A table goes through the load register, each butterfly stage register and the serialiser.
// One word per cycle goes out while m_tready is high; the serialiser takes a new spectrum only
// with the old one's last word, setting the table rate; a stalled output holds every full stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the variable count to 6.
// Top level: APB register, table load stage, butterfly stages and the serialiser.
// Depends on wst_pkg, wst_bfly_stage, wst_emit and the assertion macro header.
`default_nettype none
`include "walsh_spectrum_of_truth_table_unit_defines.svh"

module walsh_spectrum_of_truth_table_unit #(
    parameter int MAX_VARS = wst_pkg::DEFAULT_MAX_VARS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // truth_table [63:0]
    input  wire logic [wst_pkg::TT_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // coeff_index [5:0], coefficient [13:6], zero padding [15:14]
    output logic [wst_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // last_coeff
    output logic                                 m_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wst_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [wst_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wst_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import wst_pkg::*;

    localparam int LANES = 1 << MAX_VARS;
    localparam int CNT_W = MAX_VARS + 1;

    logic [NV_W-1:0]              var_count_reg;
    logic [REG_IDX_W-1:0]         reg_idx;
    logic [NV_W-1:0]              nv_sat;
    logic [CNT_W-1:0]             ld_size;
    logic [LANES-1:0][COEF_W-1:0] ld_data_next;
    logic [LANES-1:0][COEF_W-1:0] ld_data_reg;
    wst_ctl_t                     ld_ctl_reg;
    wst_ctl_t                     ld_ctl_next;

    wst_ctl_t                     st_ctl   [MAX_VARS+1];
    logic [LANES-1:0][COEF_W-1:0] st_data  [MAX_VARS+1];
    logic                         st_ready [MAX_VARS+1];

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg <= VAR_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_IDX_VAR_COUNT))
        begin
            var_count_reg <= pwdata[NV_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IDX_VAR_COUNT: prdata = APB_DATA_W'(var_count_reg);
            default:           prdata = '0;
        endcase
    end

    // Load stage: unused table bits are cleared and each bit becomes a lane value.
    assign nv_sat  = (var_count_reg > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : var_count_reg;
    assign ld_size = CNT_W'(1) << nv_sat;

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            ld_data_next[j] = (CNT_W'(j) < ld_size) ? COEF_W'(s_tdata[j]) : '0;
        end
        ld_ctl_next.valid = s_tvalid;
        ld_ctl_next.nvars = nv_sat;
    end

    assign s_tready = !ld_ctl_reg.valid || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_ctl_reg <= '0;
        end
        else if (s_tready)
        begin
            ld_ctl_reg <= ld_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            ld_data_reg <= ld_data_next;
        end
    end

    assign st_ctl[0]  = ld_ctl_reg;
    assign st_data[0] = ld_data_reg;

    for (genvar s = 0; s < MAX_VARS; s++)
    begin : g_stage
        wst_bfly_stage #(
            .LANES (LANES),
            .STAGE (s)
        ) u_bfly (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_ctl    (st_ctl[s]),
            .in_data   (st_data[s]),
            .in_ready  (st_ready[s]),
            .out_ctl   (st_ctl[s+1]),
            .out_data  (st_data[s+1]),
            .out_ready (st_ready[s+1])
        );
    end

    wst_emit #(
        .LANES (LANES),
        .CNT_W (CNT_W)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (st_ctl[MAX_VARS]),
        .in_data  (st_data[MAX_VARS]),
        .in_ready (st_ready[MAX_VARS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `WST_ASSERT_NEXT(a_load_fills, clk, rst_n, s_tvalid && s_tready, ld_ctl_reg.valid, "accepted table did not reach the load stage")
    `WST_ASSERT_NEXT(a_index_steps, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1), "coefficient index did not advance by one")
    `WST_ASSERT_NEXT(a_restart_zero, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata[5:0] == 6'd0), "new spectrum did not start at index zero")
    `WST_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[15:14] == 2'b00, "output padding bits are not zero")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for walsh_spectrum_of_truth_table_unit: streams truth tables
// in, predicts every Walsh coefficient word and compares the output stream field by field.
// Depends on wst_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_top;

    import wst_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int TB_MAX_VARS   = DEFAULT_MAX_VARS;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int SEG_TABLES    = 32;

    localparam logic [APB_ADDR_W-1:0] VAR_COUNT_ADDR = {REG_IDX_VAR_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR     = {1'b1, 2'b00};

    localparam logic [NV_W-1:0] NV_PLAN [12] =
        '{3'd6, 3'd2, 3'd0, 3'd5, 3'd7, 3'd1, 3'd3, 3'd6, 3'd4, 3'd0, 3'd6, 3'd7};

    typedef struct packed {
        logic [IDX_W-1:0]         coeff_index;
        logic signed [COEF_W-1:0] coefficient;
        logic                     last_coeff;
    } coeff_word_t;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [TT_W-1:0]            s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       m_tlast;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr    = '0;
    logic [APB_DATA_W-1:0]      pwdata   = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    logic [TT_W-1:0]  table_queue [$];
    coeff_word_t      spectrum_queue [$];
    logic [NV_W-1:0]  nv_shadow = VAR_COUNT_RESET;
    logic             table_taken = 1'b0;
    int               src_idle_pct = 0;
    int               sink_stall_pct = 0;
    logic             hold_armed = 1'b0;
    logic             hold_done = 1'b0;
    int               hold_left = 0;
    int               mismatch_count = 0;
    int               quiet_cycles = 0;

    walsh_spectrum_of_truth_table_unit #(
        .MAX_VARS (TB_MAX_VARS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void predict_spectrum(input logic [TT_W-1:0] tt);
        int n;
        int size;
        int d;
        int j;
        int a;
        int b;
        int w [64];
        coeff_word_t cw;
        n = (nv_shadow > TB_MAX_VARS) ? TB_MAX_VARS : int'(nv_shadow);
        size = 1 << n;
        for (j = 0; j < size; j++)
        begin
            w[j] = tt[j];
        end
        for (d = size / 2; d >= 1; d = d / 2)
        begin
            for (j = 0; j < size; j++)
            begin
                if ((j & d) == 0)
                begin
                    a = w[j];
                    b = w[j + d];
                    w[j] = a + b;
                    w[j + d] = a - b;
                end
            end
        end
        for (j = 0; j < size; j++)
        begin
            cw.coeff_index = IDX_W'(j);
            cw.coefficient = COEF_W'(w[j]);
            cw.last_coeff  = (j == size - 1);
            spectrum_queue.push_back(cw);
        end
    endfunction

    // Sender: a word stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || table_taken))
        begin
            if (table_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= table_queue.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom, $urandom};
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        coeff_word_t want;
        coeff_word_t got;
        table_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            predict_spectrum(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.coeff_index = m_tdata[IDX_W-1:0];
            got.coefficient = m_tdata[IDX_W+COEF_W-1:IDX_W];
            got.last_coeff  = m_tlast;
            if (spectrum_queue.size() == 0)
            begin
                $error("unexpected word: coeff_index %0d coefficient %0d last_coeff %0b",
                       got.coeff_index, got.coefficient, got.last_coeff);
                mismatch_count++;
            end
            else
            begin
                want = spectrum_queue.pop_front();
                if (got.coeff_index !== want.coeff_index)
                begin
                    $error("coeff_index: expected %0d, actual %0d",
                           want.coeff_index, got.coeff_index);
                    mismatch_count++;
                end
                if (got.coefficient !== want.coefficient)
                begin
                    $error("coefficient: expected %0d, actual %0d",
                           want.coefficient, got.coefficient);
                    mismatch_count++;
                end
                if (got.last_coeff !== want.last_coeff)
                begin
                    $error("last_coeff: expected %0b, actual %0b",
                           want.last_coeff, got.last_coeff);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (table_queue.size() != 0 || s_tvalid || spectrum_queue.size() != 0)
            @(posedge clk);
        repeat (TB_MAX_VARS + 4) @(posedge clk);
    endtask

    // Writes a register, then reads the variable count back and checks it.
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input logic [NV_W-1:0] nv);
        logic [APB_DATA_W-1:0] wdata;
        wdata = ($urandom & ~APB_DATA_W'(7)) | APB_DATA_W'(nv);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (addr == VAR_COUNT_ADDR)
            nv_shadow = nv;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= VAR_COUNT_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(nv_shadow))
        begin
            $error("var_count: expected %0d, actual %0d", nv_shadow, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int seg;
        int k;
        logic [TT_W-1:0] tt;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset value of the variable count: the full 64-point spectrum.
        table_queue.push_back('0);
        table_queue.push_back('1);
        table_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        table_queue.push_back(64'h5555_5555_5555_5555);
        table_queue.push_back(64'h0000_0000_0000_0001);
        table_queue.push_back(64'h8000_0000_0000_0000);
        table_queue.push_back(64'h8000_0000_0000_0001);
        table_queue.push_back(64'h6996_9669_9669_6996);
        wait_drained();

        // Zero variables: a single word carrying bit 0.
        write_register(VAR_COUNT_ADDR, 3'd0);
        table_queue.push_back('0);
        table_queue.push_back(64'h1);
        table_queue.push_back(~64'h1);
        table_queue.push_back('1);
        wait_drained();

        // A value above the maximum saturates.
        write_register(VAR_COUNT_ADDR, 3'd7);
        table_queue.push_back('1);
        table_queue.push_back(64'h6996_9669_9669_6996);
        table_queue.push_back({$urandom, $urandom});
        wait_drained();

        // A write to an unused address leaves the variable count alone.
        write_register(SPARE_ADDR, 3'd2);
        table_queue.push_back({$urandom, $urandom});
        wait_drained();

        // Bits above the table are ignored.
        write_register(VAR_COUNT_ADDR, 3'd1);
        for (k = 0; k < 4; k++)
        begin
            tt = {$urandom, $urandom};
            tt[1:0] = k[1:0];
            table_queue.push_back(tt);
        end
        wait_drained();

        write_register(VAR_COUNT_ADDR, 3'd3);
        table_queue.push_back({{56{1'b1}}, 8'hE8});
        table_queue.push_back(64'h0000_0000_0000_00FF);
        table_queue.push_back({{56{1'b1}}, 8'h96});
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin src_idle_pct = 17; sink_stall_pct = 17; end
            endcase
            for (seg = 0; seg < 3; seg++)
            begin
                write_register(VAR_COUNT_ADDR, NV_PLAN[ph * 3 + seg]);
                for (k = 0; k < SEG_TABLES; k++)
                begin
                    case ($urandom_range(0, 3))
                        0: tt = {$urandom, $urandom};
                        1:
                        begin
                            tt = '0;
                            repeat ($urandom_range(1, 4)) tt[$urandom_range(0, 63)] = 1'b1;
                        end
                        2:
                        begin
                            tt = '1;
                            repeat ($urandom_range(1, 4)) tt[$urandom_range(0, 63)] = 1'b0;
                        end
                        default: tt = {$urandom, $urandom} & {$urandom, $urandom};
                    endcase
                    table_queue.push_back(tt);
                end
                // The output is held off long enough for the pipeline to back up.
                if (ph == 0 && seg == 0)
                    hold_armed = 1'b1;
                wait_drained();
            end
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
